// File: rtl/tpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpba_pkg
// Shared types and constants for the thread page bump allocator.
// ----------------------------------------------------------------------------
package tpba_pkg;

  localparam int THREAD_COUNT    = 128;
  localparam int PAGE_SIZE_BYTES = 4096;

  localparam int TIDX_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int CNT_W  = $clog2(THREAD_COUNT + 1);

  localparam logic [31:0] HEAP_BYTES_RESET = 32'd16777216;

  // operation codes
  localparam logic [2:0] OP_ALLOC     = 3'd0;
  localparam logic [2:0] OP_BIND      = 3'd1;
  localparam logic [2:0] OP_UNBIND    = 3'd2;
  localparam logic [2:0] OP_CLAMP     = 3'd3;
  localparam logic [2:0] OP_COLLECTED = 3'd4;

  // result status codes
  localparam logic [1:0] ST_PAGE     = 2'd0;
  localparam logic [1:0] ST_NEW_PAGE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  typedef logic [TIDX_W-1:0] tidx_t;

  typedef struct packed {
    logic [31:0] cursor;
    logic [31:0] fence;
    logic [31:0] limit;
  } page_t;

  // page store request from the controller
  typedef struct packed {
    logic  rd_en;
    tidx_t rd_idx;
    logic  wr_en;
    tidx_t wr_idx;
    page_t wr_page;
    logic  bind_en;
    tidx_t bind_idx;
    logic  bind_active;
    logic  clear_all;
  } store_req_t;

  // registered read data from the page store
  typedef struct packed {
    page_t page;
    logic  active;
  } store_rsp_t;

  // allocation evaluation, registered between the evaluate and commit states
  typedef struct packed {
    logic        page_ok;
    logic        new_ok;
    logic [31:0] page_next;
    logic [31:0] fresh_next;
    logic [32:0] span_sum;
  } eval_t;

endpackage

// File: rtl/tpba_page_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpba_page_store
// Per-thread page memory (cursor, end, limit) with entry valid bits and the
// thread active bits. Invalid entries read as an all-zero page.
// ----------------------------------------------------------------------------
module tpba_page_store
  import tpba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output store_rsp_t rsp
);

  page_t                   mem [THREAD_COUNT];
  logic [THREAD_COUNT-1:0] valid_r;
  logic [THREAD_COUNT-1:0] active_r;
  page_t                   rd_page_r;
  logic                    rd_valid_r;
  logic                    rd_active_r;

  // memory array: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_page;
    end
    if (req.rd_en) begin
      rd_page_r   <= mem[req.rd_idx];
      rd_valid_r  <= valid_r[req.rd_idx];
      rd_active_r <= active_r[req.rd_idx];
    end
  end

  // valid and active bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      active_r <= '0;
    end else begin
      if (req.clear_all) begin
        valid_r <= '0;
      end else begin
        if (req.wr_en) begin
          valid_r[req.wr_idx] <= 1'b1;
        end
        if (req.bind_en) begin
          valid_r[req.bind_idx] <= 1'b0;
        end
      end
      if (req.bind_en) begin
        active_r[req.bind_idx] <= req.bind_active;
      end
    end
  end

  assign rsp.page   = rd_valid_r ? rd_page_r : '0;
  assign rsp.active = rd_active_r;

endmodule

// File: rtl/tpba_alloc_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpba_alloc_eval
// Checks whether a request fits the thread's page and whether a new page can
// be reserved from the bump pointer.
// ----------------------------------------------------------------------------
module tpba_alloc_eval
  import tpba_pkg::*;
(
  input  page_t       page,
  input  logic [31:0] req_bytes,
  input  logic [31:0] bump,
  input  logic [31:0] heap_bytes,
  output eval_t       ev
);

  logic [31:0] room_end;
  logic [31:0] room_lim;
  logic [31:0] left;
  logic [31:0] span;

  // current page: cursor <= end <= limit and request fits both gaps
  assign room_end   = page.fence - page.cursor;
  assign room_lim   = page.limit - page.cursor;
  assign ev.page_ok = (page.cursor <= page.fence) && (page.fence <= page.limit)
                      && (req_bytes <= room_end) && (req_bytes <= room_lim);
  assign ev.page_next = page.cursor + req_bytes;

  // new page from the bump pointer
  assign left        = heap_bytes - bump;
  assign ev.new_ok   = (bump < heap_bytes) && (left >= req_bytes);
  assign span        = (req_bytes > 32'(PAGE_SIZE_BYTES)) ? req_bytes : 32'(PAGE_SIZE_BYTES);
  assign ev.span_sum = {1'b0, bump} + {1'b0, span};
  assign ev.fresh_next = bump + req_bytes;

endmodule

// File: rtl/thread_page_bump_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_page_bump_allocator
// Bump allocator with one page per thread, backed by a page memory.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  in_      | start & !busy             | operation, thread, request, used_after
//  out_     | out_valid, one cycle      | status, offset, used/free bytes
//  cfg_     | cfg_valid & cfg_ready     | cfg_data (heap size), ready always high
//
// Allocate, bind, unbind, collection done and unknown operations go through
// accept with page read, evaluate and commit. The result shows the cycle
// after commit, when the block is already idle again. Clamp walks the page
// memory one entry a cycle through its single read port. Reset is immediate,
// valid bits stand in for a cleared memory. Results cannot be stalled.
// ----------------------------------------------------------------------------
module thread_page_bump_allocator
  import tpba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_thread,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_used_after,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_offset,
  output logic [31:0] out_used_bytes,
  output logic [31:0] out_free_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_SWEEP  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  op_r;
  logic [6:0]  thread_r;
  logic [31:0] req_r;
  logic [31:0] used_r;
  logic [31:0] bump_r, bump_nxt;
  logic [31:0] heap_r;
  eval_t       ev, ev_r;
  logic [CNT_W-1:0] sweep_r, sweep_nxt;
  logic        wb_pend_r, wb_pend_nxt;
  tidx_t       wb_idx_r;
  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] used_out_r;
  logic [31:0] free_r;
  logic        accept;
  logic        ok_thread;
  logic [31:0] chunk_end;
  store_req_t  st_req;
  store_rsp_t  st_rsp;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign ok_thread = (32'(thread_r) < 32'(THREAD_COUNT));

  // new page end, cut to the heap
  assign chunk_end = (ev_r.span_sum > {1'b0, heap_r}) ? heap_r : ev_r.span_sum[31:0];

  tpba_page_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .rsp   (st_rsp)
  );

  tpba_alloc_eval u_eval (
    .page       (st_rsp.page),
    .req_bytes  (req_r),
    .bump       (bump_r),
    .heap_bytes (heap_r),
    .ev         (ev)
  );

  // sequencer, store requests and commit
  always_comb begin
    state_nxt   = state_r;
    sweep_nxt   = sweep_r;
    wb_pend_nxt = 1'b0;
    bump_nxt    = bump_r;
    status_nxt  = ST_DONE;
    offset_nxt  = '0;
    st_req      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          st_req.rd_en  = 1'b1;
          st_req.rd_idx = tidx_t'(in_thread);
          sweep_nxt     = '0;
          state_nxt     = (in_operation == OP_CLAMP) ? S_SWEEP : S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_COMMIT;
      end
      S_SWEEP: begin
        if (sweep_r < CNT_W'(THREAD_COUNT)) begin
          st_req.rd_en  = 1'b1;
          st_req.rd_idx = sweep_r[TIDX_W-1:0];
          sweep_nxt     = sweep_r + CNT_W'(1);
          wb_pend_nxt   = 1'b1;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_nxt = S_IDLE;
        unique case (op_r) inside
          OP_ALLOC: begin
            status_nxt = ST_NO_SPACE;
            if (ok_thread && ev_r.page_ok) begin
              status_nxt     = ST_PAGE;
              offset_nxt     = st_rsp.page.cursor;
              st_req.wr_en   = 1'b1;
              st_req.wr_idx  = tidx_t'(thread_r);
              st_req.wr_page = '{cursor: ev_r.page_next,
                                 fence: st_rsp.page.fence,
                                 limit: st_rsp.page.limit};
            end else if (ok_thread && ev_r.new_ok) begin
              status_nxt     = ST_NEW_PAGE;
              offset_nxt     = bump_r;
              bump_nxt       = chunk_end;
              st_req.wr_en   = 1'b1;
              st_req.wr_idx  = tidx_t'(thread_r);
              st_req.wr_page = '{cursor: ev_r.fresh_next,
                                 fence: chunk_end,
                                 limit: chunk_end};
            end
          end
          OP_BIND, OP_UNBIND: begin
            if (ok_thread) begin
              st_req.bind_en     = 1'b1;
              st_req.bind_idx    = tidx_t'(thread_r);
              st_req.bind_active = (op_r == OP_BIND);
            end
          end
          OP_COLLECTED: begin
            bump_nxt         = used_r;
            st_req.clear_all = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // clamp write-back, one entry behind the read
    if (wb_pend_r && st_rsp.active) begin
      st_req.wr_en   = 1'b1;
      st_req.wr_idx  = wb_idx_r;
      st_req.wr_page = '{cursor: st_rsp.page.cursor,
                         fence: st_rsp.page.fence,
                         limit: st_rsp.page.cursor};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sweep_r     <= '0;
      wb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      bump_r      <= '0;
      heap_r      <= HEAP_BYTES_RESET;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      wb_pend_r   <= wb_pend_nxt;
      out_valid_r <= (state_r == S_COMMIT);
      bump_r      <= bump_nxt;
      if (cfg_valid && cfg_ready) begin
        heap_r <= cfg_data;
      end
    end
  end

  // request capture, evaluation and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      thread_r <= in_thread;
      req_r    <= in_request_bytes;
      used_r   <= in_used_after;
    end
    if (state_r == S_EVAL) begin
      ev_r <= ev;
    end
    wb_idx_r <= sweep_r[TIDX_W-1:0];
    if (state_r == S_COMMIT) begin
      status_r   <= status_nxt;
      offset_r   <= offset_nxt;
      used_out_r <= bump_nxt;
      free_r     <= (heap_r > bump_nxt) ? (heap_r - bump_nxt) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_offset     = offset_r;
  assign out_used_bytes = used_out_r;
  assign out_free_bytes = free_r;

endmodule

// File: rtl/tpba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpba_checker
// Port-level checks for the thread page bump allocator, bound to the top.
// ----------------------------------------------------------------------------
module tpba_checker
  import tpba_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_offset
);

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // never two results in a row
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // result is shown once the work is finished
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // offset is zero unless a block was granted
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NO_SPACE || out_status == ST_DONE))
      |-> (out_offset == '0))
    else $error("offset set without a grant");

endmodule

bind thread_page_bump_allocator tpba_checker u_tpba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_offset (out_offset)
);

// File: tb/thread_page_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_page_checker
// Passive scoreboard for the thread page bump allocator. It follows every
// accepted request and heap size write, keeps its own copy of the per-thread
// pages and the bump pointer, and compares each result strobe field by field
// with the oldest predicted grant.
// ----------------------------------------------------------------------------
module thread_page_checker
  import tpba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_thread,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_used_after,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_offset,
  input  logic [31:0] out_used_bytes,
  input  logic [31:0] out_free_bytes,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          checked,
  output int          new_pages,
  output int          refusals
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [31:0] used;
    logic [31:0] free;
  } grant_t;

  grant_t      awaited_grants[$];
  logic [31:0] heap_cap;
  logic [31:0] bump_ptr;
  logic [31:0] pg_cursor [THREAD_COUNT];
  logic [31:0] pg_end    [THREAD_COUNT];
  logic [31:0] pg_limit  [THREAD_COUNT];
  logic        thr_active[THREAD_COUNT];
  int          fail_tally  = 0;
  int          check_tally = 0;
  int          fresh_tally = 0;
  int          refuse_tally = 0;

  function automatic void clear_page(input int t);
    pg_cursor[t] = '0;
    pg_end[t]    = '0;
    pg_limit[t]  = '0;
  endfunction

  // carve req bytes from the thread's current page, if it is consistent
  function automatic logic carve_page(input int t, input logic [31:0] req,
                                      output logic [31:0] where);
    logic [31:0] c;
    logic [31:0] e;
    logic [31:0] l;
    c     = pg_cursor[t];
    e     = pg_end[t];
    l     = pg_limit[t];
    where = '0;
    if (c > e || e > l) return 1'b0;
    if (req > e - c || req > l - c) return 1'b0;
    where        = c;
    pg_cursor[t] = c + req;
    return 1'b1;
  endfunction

  // take a fresh page of max(page size, req) bytes, cut to what is left
  function automatic logic reserve_page(input int t, input logic [31:0] req);
    logic [31:0] left;
    logic [31:0] chunk;
    if (bump_ptr >= heap_cap) return 1'b0;
    left = heap_cap - bump_ptr;
    if (left < req) return 1'b0;
    chunk = (req > 32'(PAGE_SIZE_BYTES)) ? req : 32'(PAGE_SIZE_BYTES);
    if (chunk > left) chunk = left;
    pg_cursor[t] = bump_ptr;
    pg_end[t]    = bump_ptr + chunk;
    pg_limit[t]  = bump_ptr + chunk;
    bump_ptr     = bump_ptr + chunk;
    return 1'b1;
  endfunction

  // update the allocator state for one request and work out its grant
  function automatic grant_t apply_request(input logic [2:0] op, input logic [6:0] thr,
                                           input logic [31:0] req,
                                           input logic [31:0] used_after);
    grant_t      g;
    logic [31:0] where;
    logic        in_range;
    in_range = (int'(thr) < THREAD_COUNT);
    g.status = ST_DONE;
    g.offset = '0;
    case (op) inside
      OP_ALLOC: begin
        g.status = ST_NO_SPACE;
        if (in_range) begin
          if (carve_page(thr, req, where)) begin
            g.status = ST_PAGE;
            g.offset = where;
          end else if (reserve_page(thr, req) && carve_page(thr, req, where)) begin
            g.status = ST_NEW_PAGE;
            g.offset = where;
          end
        end
      end
      OP_BIND, OP_UNBIND: begin
        if (in_range) begin
          thr_active[thr] = (op == OP_BIND);
          clear_page(thr);
        end
      end
      OP_CLAMP: begin
        for (int i = 0; i < THREAD_COUNT; i++)
          if (thr_active[i]) pg_limit[i] = pg_cursor[i];
      end
      OP_COLLECTED: begin
        bump_ptr = used_after;
        for (int i = 0; i < THREAD_COUNT; i++) clear_page(i);
      end
      default: ;
    endcase
    g.used = bump_ptr;
    g.free = (heap_cap > bump_ptr) ? heap_cap - bump_ptr : '0;
    return g;
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want === got) return 0;
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    return 1;
  endfunction

  // sample both channels at the clock edge, results before new requests
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    grant_t g;
    if (!rst_n) begin
      heap_cap = HEAP_BYTES_RESET;
      bump_ptr = '0;
      for (int i = 0; i < THREAD_COUNT; i++) begin
        clear_page(i);
        thr_active[i] = 1'b0;
      end
      awaited_grants.delete();
    end else begin
      if (out_valid) begin
        got = '{out_status, out_offset, out_used_bytes, out_free_bytes};
        if (awaited_grants.size() == 0) begin
          $display("%0t ns: result with nothing expected, status %0d offset %h used %h free %h",
                   $time, out_status, out_offset, out_used_bytes, out_free_bytes);
          fail_tally++;
        end else begin
          want = awaited_grants.pop_front();
          check_tally++;
          fail_tally += field_differs("status", 32'(want.status), 32'(got.status));
          fail_tally += field_differs("offset", want.offset, got.offset);
          fail_tally += field_differs("used_bytes", want.used, got.used);
          fail_tally += field_differs("free_bytes", want.free, got.free);
        end
      end
      if (start && !busy) begin
        g = apply_request(in_operation, in_thread, in_request_bytes, in_used_after);
        awaited_grants.push_back(g);
        if (g.status == ST_NEW_PAGE) fresh_tally++;
        if (g.status == ST_NO_SPACE) refuse_tally++;
      end
      if (cfg_valid && cfg_ready) heap_cap = cfg_data;
    end
    outstanding <= awaited_grants.size();
    mismatches  <= fail_tally;
    checked     <= check_tally;
    new_pages   <= fresh_tally;
    refusals    <= refuse_tally;
  end

endmodule

// File: tb/thread_page_bump_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_page_bump_allocator_test
// Drives the allocator with a directed opening (zero requests, page reuse,
// fresh and cut pages, clamp, heap exhaustion, unknown operations) and then
// random request mixes over several heap sizes, 0 and all-ones among them.
// Checking is done by thread_page_checker; this module makes the stimulus.
// ----------------------------------------------------------------------------
module thread_page_bump_allocator_test
  import tpba_pkg::*;
();

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 182;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic [2:0]  in_operation     = OP_ALLOC;
  logic [6:0]  in_thread        = '0;
  logic [31:0] in_request_bytes = '0;
  logic [31:0] in_used_after    = '0;
  logic        cfg_valid        = 1'b0;
  logic [31:0] cfg_data         = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_offset;
  logic [31:0] out_used_bytes;
  logic [31:0] out_free_bytes;
  logic        cfg_ready;

  int          mismatches;
  int          outstanding;
  int          checked;
  int          new_pages;
  int          refusals;
  int          sent         = 0;
  int          clamps       = 0;
  int          stall_cycles = 0;
  logic        gaps_on      = 1'b1;
  logic [31:0] heap_now     = HEAP_BYTES_RESET;
  logic [31:0] heap_plan[6] = '{32'd65536, 32'd0, 32'd20000, 32'hFFFF_FFFF,
                                32'd300000, HEAP_BYTES_RESET};

  thread_page_bump_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_thread        (in_thread),
    .in_request_bytes (in_request_bytes),
    .in_used_after    (in_used_after),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_offset       (out_offset),
    .out_used_bytes   (out_used_bytes),
    .out_free_bytes   (out_free_bytes),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  thread_page_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_thread        (in_thread),
    .in_request_bytes (in_request_bytes),
    .in_used_after    (in_used_after),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_offset       (out_offset),
    .out_used_bytes   (out_used_bytes),
    .out_free_bytes   (out_free_bytes),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .checked          (checked),
    .new_pages        (new_pages),
    .refusals         (refusals)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles at %0t ns", stall_cycles, $time);
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // present one request and hold it until the block takes it
  task automatic issue(input logic [2:0] op, input logic [6:0] thr,
                       input logic [31:0] req, input logic [31:0] used);
    start            <= 1'b1;
    in_operation     <= op;
    in_thread        <= thr;
    in_request_bytes <= req;
    in_used_after    <= used;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (op == OP_CLAMP) clamps++;
  endtask

  // stop sending until every pending result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic set_heap(input logic [31:0] bytes);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= bytes;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    heap_now = bytes;
  endtask

  // mostly allocations on a handful of threads, with binds, clamps,
  // collections and the odd unknown or fully random request
  task automatic random_request();
    logic [2:0]  op;
    logic [6:0]  thr;
    logic [31:0] req;
    logic [31:0] used;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 62) op = OP_ALLOC;
    else if (pick < 72) op = OP_BIND;
    else if (pick < 80) op = OP_UNBIND;
    else if (pick < 84) op = OP_CLAMP;
    else if (pick < 90) op = OP_COLLECTED;
    else if (pick < 94) op = OP_COLLECTED + 3'($urandom_range(1, 3));
    else op = 3'($urandom);
    thr = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 7)) : 7'($urandom);
    case ($urandom_range(0, 9)) inside
      0:       req = '0;
      1, 2, 3: req = $urandom_range(1, 256);
      4, 5:    req = $urandom_range(0, 2 * PAGE_SIZE_BYTES);
      6:       req = $urandom_range(PAGE_SIZE_BYTES - 4, PAGE_SIZE_BYTES + 4);
      7:       req = $urandom_range(0, heap_now);
      8:       req = $urandom_range(0, 16 * PAGE_SIZE_BYTES);
      default: req = $urandom;
    endcase
    case ($urandom_range(0, 9)) inside
      0, 1:       used = '0;
      2, 3, 4, 5: used = $urandom_range(0, heap_now / 2);
      6, 7:       used = heap_now - $urandom_range(0, 3 * PAGE_SIZE_BYTES);
      8:          used = heap_now + $urandom_range(0, 8);
      default:    used = $urandom;
    endcase
    issue(op, thr, req, used);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at the reset heap size
    issue(OP_ALLOC, 7'd0, 32'd0, $urandom);          // zero request on an empty page
    issue(OP_ALLOC, 7'd0, 32'd100, $urandom);        // first fresh page
    issue(OP_ALLOC, 7'd0, 32'd200, $urandom);        // same page
    issue(OP_ALLOC, 7'd1, 32'd5000, $urandom);       // page larger than the default
    issue(OP_BIND, 7'd127, $urandom, $urandom);
    issue(OP_ALLOC, 7'd127, 32'hFFFF_FFFF, 32'd0);   // more than the heap
    issue(OP_ALLOC, 7'd127, 32'd16, 32'hFFFF_FFFF);
    issue(OP_CLAMP, 7'd0, $urandom, $urandom);
    issue(OP_ALLOC, 7'd127, 32'd1, $urandom);        // clamped page forces a new one
    issue(OP_ALLOC, 7'd127, 32'd0, $urandom);
    issue(OP_ALLOC, 7'd1, 32'd1, $urandom);          // unbound thread still allocates
    issue(OP_UNBIND, 7'd127, $urandom, $urandom);
    issue(OP_COLLECTED, 7'd0, 32'd0, 32'hFFFF_FFFF); // used beyond the heap
    issue(OP_ALLOC, 7'd2, 32'd8, $urandom);          // bump pointer past the end
    for (int k = 1; k <= 3; k++)
      issue(OP_COLLECTED + 3'(k), 7'($urandom), $urandom, $urandom);
    issue(OP_COLLECTED, 7'd5, $urandom, HEAP_BYTES_RESET - 32'd100);
    issue(OP_ALLOC, 7'd3, 32'd64, $urandom);         // page cut to what is left
    issue(OP_ALLOC, 7'd3, 32'd36, $urandom);
    issue(OP_ALLOC, 7'd3, 32'd1, $urandom);          // heap exhausted
    issue(OP_COLLECTED, 7'd0, $urandom, 32'd0);
    issue(OP_BIND, 7'd0, $urandom, $urandom);

    // random phases, one per heap size, the last one without gaps
    for (int phase = 0; phase <= 6; phase++) begin
      if (phase > 0) set_heap(heap_plan[phase - 1]);
      gaps_on = (phase < 6);
      repeat (PHASE_ITEMS) begin
        sender_gap();
        if ($urandom_range(0, 99) == 0) drain();
        random_request();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run: %0d requests over 7 heap sizes, %0d results checked, %0d clamps",
             sent, checked, clamps);
    $display("run: %0d grants from fresh pages, %0d out-of-space answers",
             new_pages, refusals);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: thread_page_bump_allocator.f
rtl/tpba_pkg.sv
rtl/tpba_page_store.sv
rtl/tpba_alloc_eval.sv
rtl/thread_page_bump_allocator.sv
rtl/tpba_checker.sv
tb/thread_page_checker.sv
tb/thread_page_bump_allocator_test.sv
